// ===== sv/vvtp_pkg.sv =====
// vvtp_pkg: widths, register indexes and shared types for the vertex
// view transform / projection block. No dependencies.
package vvtp_pkg;

  localparam int OW    = 24;            // field width, Q15.8
  localparam int DW    = OW + 1;        // vertex minus camera
  localparam int CW    = 16;            // Q1.14 coefficient
  localparam int PW    = DW + CW;       // one coefficient product
  localparam int SW    = PW + 2;        // sum of three products
  localparam int FRAC  = 14;
  localparam int VW    = SW - FRAC;     // view coordinate
  localparam int SCW   = 16;            // perspective factor, Q8.8
  localparam int NW    = VW + SCW;      // dividend magnitude
  localparam int RW    = 48;            // coefficient row / config data
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    REG_ROW_X,
    REG_ROW_Y,
    REG_ROW_Z,
    REG_CAM_X,
    REG_CAM_Y,
    REG_CAM_Z,
    REG_PERSP
  } reg_idx_e;

  typedef struct packed {
    logic [RW-1:0]        row_x;
    logic [RW-1:0]        row_y;
    logic [RW-1:0]        row_z;
    logic signed [OW-1:0] cam_x;
    logic signed [OW-1:0] cam_y;
    logic signed [OW-1:0] cam_z;
    logic [SCW-1:0]       persp;
  } cfg_t;

  // One vertex handed from the transform front to the divide back.
  typedef struct packed {
    logic [NW-1:0]        num_x;
    logic [NW-1:0]        num_y;
    logic                 neg_x;
    logic                 neg_y;
    logic [VW-1:0]        den;
    logic signed [VW-1:0] zv;
    logic                 last;
  } job_t;

endpackage

// ===== sv/vvtp_front.sv =====
// vvtp_front: camera subtract, 3x3 rotation, magnitudes and perspective
// multiply in five stalling stages. Depends on vvtp_pkg.
module vvtp_front import vvtp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [OW-1:0] vx_i,
  input  logic signed [OW-1:0] vy_i,
  input  logic signed [OW-1:0] vz_i,
  input  logic                 last_in_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output job_t                 job_o
);

  logic en;
  logic [4:0] v_q;

  logic signed [DW-1:0] d_q [3];
  logic                 l1_q, l2_q, l3_q, l4_q;
  logic signed [PW-1:0] p_q [3][3];
  logic signed [VW-1:0] vw_q [3];
  logic [VW-1:0]        mx_q, my_q, den_q;
  logic                 nx_q, ny_q;
  logic signed [VW-1:0] z4_q;
  job_t                 job_q;

  logic [RW-1:0]        rows [3];
  logic signed [SW-1:0] sum [3];
  logic signed [SW-1:0] shf [3];
  logic [VW-1:0]        az;

  assign en         = !v_q[4] || job_ready_i;
  assign in_ready_o = en;
  assign rows[0]    = cfg_i.row_x;
  assign rows[1]    = cfg_i.row_y;
  assign rows[2]    = cfg_i.row_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = {{2{p_q[r][0][PW-1]}}, p_q[r][0]} + {{2{p_q[r][1][PW-1]}}, p_q[r][1]}
             + {{2{p_q[r][2][PW-1]}}, p_q[r][2]};
      shf[r] = sum[r] >>> FRAC;   // floor
    end
    az = vw_q[2][VW-1] ? VW'(-vw_q[2]) : VW'(vw_q[2]);
    if (az == '0) az = VW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[3:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q[0] <= {vx_i[OW-1], vx_i} - {cfg_i.cam_x[OW-1], cfg_i.cam_x};
      d_q[1] <= {vy_i[OW-1], vy_i} - {cfg_i.cam_y[OW-1], cfg_i.cam_y};
      d_q[2] <= {vz_i[OW-1], vz_i} - {cfg_i.cam_z[OW-1], cfg_i.cam_z};
      l1_q   <= last_in_i;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_q[r][c] <= $signed(rows[r][c*CW +: CW]) * d_q[c];
        end
      end
      l2_q <= l1_q;
      for (int r = 0; r < 3; r++) vw_q[r] <= shf[r][VW-1:0];
      l3_q  <= l2_q;
      nx_q  <= vw_q[0][VW-1];
      ny_q  <= vw_q[1][VW-1];
      mx_q  <= vw_q[0][VW-1] ? VW'(-vw_q[0]) : VW'(vw_q[0]);
      my_q  <= vw_q[1][VW-1] ? VW'(-vw_q[1]) : VW'(vw_q[1]);
      den_q <= az;
      z4_q  <= vw_q[2];
      l4_q  <= l3_q;
      job_q.num_x <= NW'(mx_q) * NW'(cfg_i.persp);
      job_q.num_y <= NW'(my_q) * NW'(cfg_i.persp);
      job_q.neg_x <= nx_q;
      job_q.neg_y <= ny_q;
      job_q.den   <= den_q;
      job_q.zv    <= z4_q;
      job_q.last  <= l4_q;
    end
  end

  assign job_valid_o = v_q[4];
  assign job_o       = job_q;

endmodule

// ===== sv/vvtp_queue.sv =====
// vvtp_queue: four-entry job queue between front and back.
// Depends on vvtp_pkg.
module vvtp_queue import vvtp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  job_t          mem [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q;
  logic           do_push, do_pop;

  assign full_o  = cnt_q == (QAW+1)'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem[wr_q] <= data_i;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAW+1)'(QDEPTH)) else $error("queue count overflow");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || full_o) |-> wr_q == rd_q) else $error("queue pointers");
`endif

endmodule

// ===== sv/vvtp_back.sv =====
// vvtp_back: restoring divide pipeline (one quotient bit per stage),
// sign restore, saturation and output register. Depends on vvtp_pkg.
module vvtp_back import vvtp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  job_t                 job_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [OW-1:0] proj_x_o,
  output logic signed [OW-1:0] proj_y_o,
  output logic signed [OW-1:0] depth_o,
  output logic                 clipped_o,
  output logic                 last_out_o
);

  typedef struct packed {
    logic [NW-1:0]        qx;
    logic [NW-1:0]        qy;
    logic [VW:0]          rx;
    logic [VW:0]          ry;
    logic [VW-1:0]        den;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [VW-1:0] zv;
    logic                 last;
  } div_t;

  localparam logic [NW-1:0] PMAX = NW'((1 << (OW-1)) - 1);
  localparam logic [NW-1:0] NMAX = NW'(1 << (OW-1));

  // one restoring step: returns {shifted quotient/dividend, remainder}
  function automatic logic [NW+VW:0] step(logic [NW-1:0] n, logic [VW:0] r,
                                          logic [VW-1:0] den);
    logic [VW:0] r2;
    logic        b;
    r2 = {r[VW-1:0], n[NW-1]};
    b  = r2 >= {1'b0, den};
    if (b) r2 = r2 - {1'b0, den};
    return {n[NW-2:0], b, r2};
  endfunction

  function automatic div_t adv(div_t s);
    div_t o;
    o = s;
    {o.qx, o.rx} = step(s.qx, s.rx, s.den);
    {o.qy, o.ry} = step(s.qy, s.ry, s.den);
    return o;
  endfunction

  function automatic logic [OW:0] sat_q(logic [NW-1:0] q, logic neg);
    logic [OW-1:0] m;
    m = q[OW-1:0];
    if (!neg && q > PMAX) return {1'b1, 1'b0, {(OW-1){1'b1}}};
    if (neg && q > NMAX)  return {1'b1, 1'b1, {(OW-1){1'b0}}};
    return {1'b0, neg ? OW'(-m) : m};
  endfunction

  div_t       st_q [NW];
  logic [NW-1:0] v_q;
  logic       en, out_v_q;
  div_t       head, fin;
  logic [OW:0] sx, sy;
  logic       zclip;
  logic signed [OW-1:0] zsat;

  assign en    = !out_v_q || out_ready_i;
  assign pop_o = en && !empty_i;

  always_comb begin
    head       = '0;
    head.qx    = job_i.num_x;
    head.qy    = job_i.num_y;
    head.den   = job_i.den;
    head.neg_x = job_i.neg_x;
    head.neg_y = job_i.neg_y;
    head.zv    = job_i.zv;
    head.last  = job_i.last;
    fin        = st_q[NW-1];
    sx         = sat_q(fin.qx, fin.neg_x);
    sy         = sat_q(fin.qy, fin.neg_y);
    zclip      = 1'b0;
    zsat       = fin.zv[OW-1:0];
    if (fin.zv > VW'(signed'(PMAX[OW-1:0]))) begin
      zclip = 1'b1;
      zsat  = {1'b0, {(OW-1){1'b1}}};
    end else if (fin.zv < -(VW'($signed({1'b0, NMAX[OW-1:0]})))) begin
      zclip = 1'b1;
      zsat  = {1'b1, {(OW-1){1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q     <= {v_q[NW-2:0], !empty_i};
      out_v_q <= v_q[NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= adv(head);
      for (int i = 1; i < NW; i++) st_q[i] <= adv(st_q[i-1]);
      proj_x_o   <= sx[OW-1:0];
      proj_y_o   <= sy[OW-1:0];
      depth_o    <= zsat;
      clipped_o  <= sx[OW] | sy[OW] | zclip;
      last_out_o <= fin.last;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

// ===== sv/vertex_view_transform_project_unit.sv =====
// Vertex view transform and perspective projection: configuration
// registers plus front, queue and back. Depends on vvtp_pkg and submodules.
// Path: front stages, job queue, 45 divide stages and an output
// register.
// Throughput: one vertex beat per cycle when the output is not stalled, set by the pipelined divider.
// Reset (async, active low) empties all stages and loads identity rows,
// zero camera and a perspective factor of 15.0.
module vertex_view_transform_project_unit import vvtp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [RW-1:0]        cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [OW-1:0] vx_i,
  input  logic signed [OW-1:0] vy_i,
  input  logic signed [OW-1:0] vz_i,
  input  logic                 last_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [OW-1:0] proj_x_o,
  output logic signed [OW-1:0] proj_y_o,
  output logic signed [OW-1:0] depth_o,
  output logic                 clipped_o,
  output logic                 last_out_o
);

  // Configuration registers; the user must write them only while idle, which the
  // block itself does not enforce, as the pipeline reads them live.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_x <= RW'(64'd16384);
      cfg_q.row_y <= RW'(64'd16384) << 16;
      cfg_q.row_z <= RW'(64'd16384) << 32;
      cfg_q.cam_x <= '0;
      cfg_q.cam_y <= '0;
      cfg_q.cam_z <= '0;
      cfg_q.persp <= SCW'(3840);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ROW_X: cfg_q.row_x <= cfg_data_i;
        REG_ROW_Y: cfg_q.row_y <= cfg_data_i;
        REG_ROW_Z: cfg_q.row_z <= cfg_data_i;
        REG_CAM_X: cfg_q.cam_x <= cfg_data_i[OW-1:0];
        REG_CAM_Y: cfg_q.cam_y <= cfg_data_i[OW-1:0];
        REG_CAM_Z: cfg_q.cam_z <= cfg_data_i[OW-1:0];
        REG_PERSP: cfg_q.persp <= cfg_data_i[SCW-1:0];
        default:   ;  // unmapped index: ignored
      endcase
    end
  end

  // Front: subtract, rotate, magnitudes, perspective multiply.
  logic job_valid, q_full, q_empty, q_pop;
  job_t job_in, job_out;

  vvtp_front u_front (
    .clk_i, .rst_ni,
    .cfg_i       (cfg_q),
    .in_valid_i, .in_ready_o,
    .vx_i, .vy_i, .vz_i, .last_in_i,
    .job_valid_o (job_valid),
    .job_ready_i (!q_full),
    .job_o       (job_in)
  );

  // Queue lets the front keep taking beats while the output is stalled, until the queue is full.
  vvtp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (job_valid),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (job_out)
  );

  // Back: divide by |z| (zero z already forced to one LSB), saturate.
  vvtp_back u_back (
    .clk_i, .rst_ni,
    .empty_i (q_empty),
    .job_i   (job_out),
    .pop_o   (q_pop),
    .out_valid_o, .out_ready_i,
    .proj_x_o, .proj_y_o, .depth_o, .clipped_o, .last_out_o
  );

endmodule
